### rtl/core/spq_pkg.sv
// shared types and codes for the sorted priority queue
// no dependencies
package spq_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_DUP   = 2'd3
  } status_e;

  // operation codes on the input tuser
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  // match bits are reduced in groups of this size
  localparam int unsigned GroupSize = 16;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic pop_en;
  } spq_ctl_t;

endpackage

### rtl/core/spq_cell.sv
// one slot of the shift-register priority queue
// depends on spq_pkg (spq_ctl_t)
module spq_cell #(
  parameter int unsigned PRIO_W = 32,
  parameter int unsigned TAG_W  = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spq_pkg::spq_ctl_t    ctl_i,
  input  logic [PRIO_W-1:0]    new_prio_i,
  input  logic [TAG_W-1:0]     new_tag_i,
  // left neighbor (lower slot)
  input  logic                 prev_valid_i,
  input  logic [PRIO_W-1:0]    prev_prio_i,
  input  logic [TAG_W-1:0]     prev_tag_i,
  input  logic                 prev_gt_i,
  // right neighbor (higher slot)
  input  logic                 next_valid_i,
  input  logic [PRIO_W-1:0]    next_prio_i,
  input  logic [TAG_W-1:0]     next_tag_i,
  output logic                 valid_o,
  output logic [PRIO_W-1:0]    prio_o,
  output logic [TAG_W-1:0]     tag_o,
  output logic                 gt_o,
  output logic                 match_o
);
  import spq_pkg::*;

  logic              valid_q, valid_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic              gt_q, gt_d;
  logic              match_q, match_d;

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    tag_d   = tag_q;
    gt_d    = gt_q;
    match_d = match_q;
    if (ctl_i.cmp_en) begin
      // new entry goes in front of this slot if the slot is empty or larger
      gt_d    = !valid_q || (prio_q > new_prio_i);
      match_d = valid_q && (tag_q == new_tag_i);
    end
    if (ctl_i.ins_en && gt_q) begin
      if (prev_gt_i) begin
        valid_d = prev_valid_i;
        prio_d  = prev_prio_i;
        tag_d   = prev_tag_i;
      end else begin
        valid_d = 1'b1;
        prio_d  = new_prio_i;
        tag_d   = new_tag_i;
      end
    end
    if (ctl_i.pop_en) begin
      valid_d = next_valid_i;
      prio_d  = next_prio_i;
      tag_d   = next_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      gt_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      gt_q    <= gt_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign valid_o = valid_q;
  assign prio_o  = prio_q;
  assign tag_o   = tag_q;
  assign gt_o    = gt_q;
  assign match_o = match_q;

endmodule

### rtl/core/sorted_priority_queue_top.sv
// top level of the sorted priority queue: sequencer, match reduction, output register
// depends on spq_pkg and spq_cell
//
// usage:
//  - input stream (s_axis): one transaction is one operation. tuser carries func
//    (0 insert, 1 pop); tdata carries new_priority in the low bits, then new_tag.
//  - output stream (m_axis): exactly one transaction per operation, in order.
//    tuser carries status (0 ok, 1 pop on empty, 2 insert on full, 3 duplicate
//    tag); tdata carries out_priority, out_tag, occupancy from the lowest bit up.
//  - the result passes the compare in every cell, the grouped or-reduction of tag
//    matches and the execute step in turn, then goes to the output register.
//  - no new operation is taken until the current one leaves its execute step; it
//    goes through the accept, compare, reduce and execute steps across the cell chain.
//  - the result sits in an output register, so s_axis takes the next operation
//    while a result waits; a stalled m_axis holds the block in its execute step.
//  - reset (rst_ni low, asynchronous) empties the queue and drops any
//    pending result; no clearing pass is needed.
module sorted_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH   = 256,
  parameter int unsigned PRIORITY_BITS = 32,
  parameter int unsigned TAG_BITS      = 9,
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned InW   = ((PRIORITY_BITS + TAG_BITS + 7) / 8) * 8,
  localparam int unsigned OutW  = ((PRIORITY_BITS + TAG_BITS + CntW + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,   // new_priority, new_tag, zero pad
  input  logic            s_axis_tuser,   // func
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,   // out_priority, out_tag, occupancy, zero pad
  output logic [1:0]      m_axis_tuser    // status
);
  import spq_pkg::*;

  localparam int unsigned Groups  = (QUEUE_DEPTH + GroupSize - 1) / GroupSize;
  localparam int unsigned PadW    = OutW - (PRIORITY_BITS + TAG_BITS + CntW);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_RED  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state_q, state_d;

  // latched operation
  logic                     func_q;
  logic [PRIORITY_BITS-1:0] new_prio_q;
  logic [TAG_BITS-1:0]      new_tag_q;

  logic [CntW-1:0] count_q, count_d;

  // cell chain wires
  logic                     cell_valid [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]      cell_tag   [QUEUE_DEPTH];
  logic                     cell_gt    [QUEUE_DEPTH];
  logic                     cell_match [QUEUE_DEPTH];

  // grouped match reduction
  logic [Groups-1:0] grp_q, grp_d;

  // output register
  logic                     out_vld_q, out_vld_d;
  status_e                  out_status_q, out_status_d;
  logic [PRIORITY_BITS-1:0] out_prio_q, out_prio_d;
  logic [TAG_BITS-1:0]      out_tag_q, out_tag_d;
  logic [CntW-1:0]          out_occ_q;

  spq_ctl_t ctl;
  logic     in_fire;
  logic     exec_go;
  logic     dup;
  logic     full;
  logic     empty;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // the result register must be free before an operation commits
  assign exec_go       = (state_q == S_EXEC) && (!out_vld_q || m_axis_tready);

  assign dup   = |grp_q;
  assign full  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  // group or-reduction of the per-cell tag matches
  always_comb begin
    grp_d = grp_q;
    if (state_q == S_RED) begin
      for (int g = 0; g < int'(Groups); g++) begin
        grp_d[g] = 1'b0;
        for (int k = 0; k < int'(GroupSize); k++) begin
          if (g * int'(GroupSize) + k < int'(QUEUE_DEPTH)) begin
            grp_d[g] = grp_d[g] | cell_match[g * int'(GroupSize) + k];
          end
        end
      end
    end
  end

  // sequencer and execute decision
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ctl          = '0;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_prio_d   = out_prio_q;
    out_tag_d    = out_tag_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_CMP;
      end
      S_CMP: begin
        // every cell compares against the latched entry
        ctl.cmp_en = 1'b1;
        state_d    = S_RED;
      end
      S_RED: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d    = S_IDLE;
          out_vld_d  = 1'b1;
          out_prio_d = '0;
          out_tag_d  = '0;
          if (func_q == FUNC_POP) begin
            if (empty) begin
              out_status_d = STATUS_EMPTY;
            end else begin
              out_status_d = STATUS_OK;
              out_prio_d   = cell_prio[0];
              out_tag_d    = cell_tag[0];
              ctl.pop_en   = 1'b1;
              count_d      = count_q - CntW'(1);
            end
          end else begin
            priority if (dup) begin
              out_status_d = STATUS_DUP;
            end else if (full) begin
              out_status_d = STATUS_FULL;
            end else begin
              out_status_d = STATUS_OK;
              ctl.ins_en   = 1'b1;
              count_d      = count_q + CntW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      grp_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
      grp_q     <= grp_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q     <= s_axis_tuser;
      new_prio_q <= s_axis_tdata[PRIORITY_BITS-1:0];
      new_tag_q  <= s_axis_tdata[PRIORITY_BITS +: TAG_BITS];
    end
    out_status_q <= out_status_d;
    out_prio_q   <= out_prio_d;
    out_tag_q    <= out_tag_d;
    if (exec_go) out_occ_q <= count_d;
  end

  // chain of slots, slot 0 holds the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     prev_valid;
    logic [PRIORITY_BITS-1:0] prev_prio;
    logic [TAG_BITS-1:0]      prev_tag;
    logic                     prev_gt;
    logic                     next_valid;
    logic [PRIORITY_BITS-1:0] next_prio;
    logic [TAG_BITS-1:0]      next_tag;

    if (i == 0) begin : g_first
      // nothing ahead of the head, so a shifting head takes the new entry
      assign prev_valid = 1'b0;
      assign prev_prio  = '0;
      assign prev_tag   = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_valid = cell_valid[i-1];
      assign prev_prio  = cell_prio[i-1];
      assign prev_tag   = cell_tag[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      // slot vacated by a pop is cleared
      assign next_valid = 1'b0;
      assign next_prio  = '0;
      assign next_tag   = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_prio  = cell_prio[i+1];
      assign next_tag   = cell_tag[i+1];
    end

    spq_cell #(
      .PRIO_W (PRIORITY_BITS),
      .TAG_W  (TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_prio_i   (new_prio_q),
      .new_tag_i    (new_tag_q),
      .prev_valid_i (prev_valid),
      .prev_prio_i  (prev_prio),
      .prev_tag_i   (prev_tag),
      .prev_gt_i    (prev_gt),
      .next_valid_i (next_valid),
      .next_prio_i  (next_prio),
      .next_tag_i   (next_tag),
      .valid_o      (cell_valid[i]),
      .prio_o       (cell_prio[i]),
      .tag_o        (cell_tag[i]),
      .gt_o         (cell_gt[i]),
      .match_o      (cell_match[i])
    );
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_occ_q, out_tag_q, out_prio_q};

endmodule

### test/sorted_priority_queue_top_tb.sv
// self-checking testbench for sorted_priority_queue_top: stream driver, stalling sink,
// and a scoreboard class that keeps its own copy of the sorted queue
// depends on spq_pkg and the sorted_priority_queue_top rtl
module sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned QDEPTH   = 256;
  localparam int unsigned PW       = 32;
  localparam int unsigned TW       = 9;
  localparam int unsigned CW       = $clog2(QDEPTH + 1);
  localparam int unsigned IN_W     = ((PW + TW + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((PW + TW + CW + 7) / 8) * 8;
  localparam int unsigned ITEMS    = 1600;
  localparam int unsigned RX_HOLD  = 400;      // long sink hold-off, in cycles
  localparam int unsigned LIMIT    = 400000;   // watchdog, far above the slowest run
  localparam int unsigned SETTLE   = 12;       // cycles waited past the last result

  typedef enum int unsigned {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;
  typedef enum int unsigned {RX_FREE, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_e;

  // one expected result transaction
  typedef struct {
    status_e       status;
    logic [PW-1:0] prio;
    logic [TW-1:0] tag;
    logic [CW-1:0] occ;
  } op_outcome_t;

  // scoreboard: sorted queue copy plus the results still awaited, oldest first
  class pq_scoreboard;
    logic [PW-1:0]  slot_prio [QDEPTH];
    logic [TW-1:0]  slot_tag  [QDEPTH];
    bit             tag_held  [1 << TW];
    int unsigned    count;
    op_outcome_t    outcome_q [$];
    int unsigned    errors;

    // apply one accepted operation to the queue copy and queue its result
    function void apply_op(logic op, logic [PW-1:0] prio, logic [TW-1:0] tag);
      op_outcome_t o;
      int unsigned pos;
      int unsigned i;
      o.status = STATUS_OK;
      o.prio   = '0;
      o.tag    = '0;
      if (op == FUNC_INSERT) begin
        // duplicate check wins over the full check
        if (tag_held[tag]) begin
          o.status = STATUS_DUP;
        end else if (count == QDEPTH) begin
          o.status = STATUS_FULL;
        end else begin
          // new entry goes behind every entry of equal or lower priority
          pos = 0;
          while (pos < count && slot_prio[pos] <= prio) pos++;
          for (i = count; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_tag[i]  = slot_tag[i-1];
          end
          slot_prio[pos] = prio;
          slot_tag[pos]  = tag;
          tag_held[tag]  = 1'b1;
          count++;
        end
      end else if (count == 0) begin
        o.status = STATUS_EMPTY;
      end else begin
        o.prio = slot_prio[0];
        o.tag  = slot_tag[0];
        tag_held[slot_tag[0]] = 1'b0;
        for (i = 0; i + 1 < count; i++) begin
          slot_prio[i] = slot_prio[i+1];
          slot_tag[i]  = slot_tag[i+1];
        end
        // vacated slot reads as zero
        slot_prio[count-1] = '0;
        slot_tag[count-1]  = '0;
        count--;
      end
      o.occ = count[CW-1:0];
      outcome_q.push_back(o);
    endfunction

    function void compare_field(string name, logic [PW-1:0] want, logic [PW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(logic [1:0] st, logic [PW-1:0] prio, logic [TW-1:0] tag,
                                logic [CW-1:0] occ);
      op_outcome_t o;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d prio %0h tag %0h occ %0d",
                 $time, st, prio, tag, occ);
        errors++;
        return;
      end
      o = outcome_q.pop_front();
      compare_field("status", PW'(o.status), PW'(st));
      compare_field("out_priority", o.prio, prio);
      compare_field("out_tag", PW'(o.tag), PW'(tag));
      compare_field("occupancy", PW'(o.occ), PW'(occ));
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;   // new_priority, new_tag, zero pad
  logic             s_axis_tuser  = 1'b0; // func
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;         // out_priority, out_tag, occupancy, zero pad
  logic [1:0]       m_axis_tuser;         // status

  pq_scoreboard sb = new;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;
  bit           rx_hold_req = 1'b0;

  sorted_priority_queue_top #(
    .QUEUE_DEPTH  (QDEPTH),
    .PRIORITY_BITS(PW),
    .TAG_BITS     (TW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // offer one operation and hold it until the input transaction completes
  task automatic send_op(input logic op, input logic [PW-1:0] prio, input logic [TW-1:0] tag);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_W-PW-TW){1'b0}}, tag, prio};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_op(op, prio, tag);
    items_sent++;
  endtask

  // sender pause: nothing offered until every awaited result is in
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_outcome(m_axis_tuser, m_axis_tdata[PW-1:0], m_axis_tdata[PW+TW-1:PW],
                       m_axis_tdata[PW+TW+CW-1:PW+TW]);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("sorted_priority_queue_top regression: fail");
      $finish;
    end
  end

  // sink: stall pattern redrawn after runs of random length, plus one long hold-off on request
  initial begin : sink
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    logic        rdy;
    mode      = RX_FREE;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD - 1;
        rdy         = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (mode)
          RX_FREE:   rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
          default:   rdy = (tick % 3) != 0;
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // stimulus
  initial begin : source
    phase_e        kind;
    int unsigned   phase_no;
    int unsigned   n;
    int unsigned   len;
    int unsigned   ins_pct;
    int unsigned   over_full;
    int unsigned   burst_left;
    int unsigned   r;
    bit            steady;
    logic          op;
    logic [PW-1:0] prio;
    logic [TW-1:0] tag;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, field extremes, ties, duplicate, drain to empty and past it
    send_op(FUNC_POP,    '1,            '1);
    send_op(FUNC_INSERT, '0,            '0);
    send_op(FUNC_INSERT, '1,            '1);
    send_op(FUNC_INSERT, 32'd5,         9'h155);
    send_op(FUNC_INSERT, 32'd5,         9'h0aa);   // tie keeps arrival order
    send_op(FUNC_INSERT, 32'haaaaaaaa,  9'h100);
    send_op(FUNC_INSERT, 32'd7,         '0);       // tag already stored
    send_op(FUNC_INSERT, '0,            9'h001);   // tie at the lowest priority
    send_op(FUNC_INSERT, 32'h55555555,  9'h0ff);
    repeat (7) send_op(FUNC_POP, $urandom, 9'($urandom));
    send_op(FUNC_POP, '0, '0);
    drain_wait();

    // random phases: fill to full, drain past empty, then phases of random kind
    phase_no   = 0;
    burst_left = 0;
    while (items_sent < ITEMS) begin
      if (phase_no == 0) kind = PH_FILL;
      else if (phase_no == 1) kind = PH_DRAIN;
      else kind = phase_e'($urandom_range(0, 2));
      case (kind)
        PH_FILL: begin
          ins_pct = 95;
          len     = 450;
        end
        PH_DRAIN: begin
          ins_pct = 10;
          len     = $urandom_range(200, 320);
        end
        default: begin
          ins_pct = $urandom_range(30, 70);
          len     = $urandom_range(40, 160);
        end
      endcase
      steady = (phase_no == 1) || ($urandom_range(0, 3) == 0);
      // long sink hold-off while the source keeps offering, queue input backs up
      if (phase_no == 1) rx_hold_req = 1'b1;
      over_full = 0;

      for (n = 0; n < len && items_sent < ITEMS; n++) begin
        if (kind == PH_FILL && sb.count == QDEPTH) begin
          over_full++;
          if (over_full > 12) break;
        end
        op = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_POP;
        r  = $urandom_range(0, 19);
        if (r < 3) prio = $urandom_range(0, 1) ? '1 : '0;
        else if (r < 11) prio = $urandom_range(0, 7);
        else prio = $urandom;
        // mostly fresh tags so the queue grows; the rest may collide
        tag = TW'($urandom_range(0, (1 << TW) - 1));
        if (op == FUNC_INSERT && $urandom_range(0, 99) < 90) begin
          while (sb.tag_held[tag]) tag = TW'($urandom_range(0, (1 << TW) - 1));
        end
        send_op(op, prio, tag);

        // unless steady, bursts of random length with idle gaps between them
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!steady) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {{(IN_W-PW-TW){1'b0}}, TW'($urandom), PW'($urandom)};
            repeat ($urandom_range(1, 8)) @(posedge clk_i);
          end
        end
      end

      if (phase_no == 1 || $urandom_range(0, 4) == 0) drain_wait();
      phase_no++;
    end

    s_axis_tvalid <= 1'b0;
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("sorted_priority_queue_top regression: pass");
    end else begin
      $display("sorted_priority_queue_top regression: fail");
    end
    $finish;
  end

endmodule
